[src/hhfe_pkg.sv]
// Shared types and constants of the HTTP header field extractor.
// No dependencies; the top level and hhfe_out_fifo import this package.
package hhfe_pkg;

    localparam int NAME_BYTES = 16;
    localparam int NIDX_W     = $clog2(NAME_BYTES);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int LEN_REG_W  = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_NAME_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_LEN  = 2'd2;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    typedef struct packed {
        logic [7:0] value_byte;
        logic       end_marker;
        logic       found;
        logic       run_final;
    } result_t;

    function automatic logic [7:0] name_byte(
        input logic [8*NAME_BYTES-1:0] name,
        input logic [NIDX_W-1:0]       k
    );
        return name[8*k +: 8];
    endfunction

endpackage

[src/hhfe_stream_if.sv]
// Valid/ready stream interfaces for the input bytes and the result items.
// No dependencies.
interface hhfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       packet_end;

    modport source (output valid, output data_byte, output packet_end, input ready);
    modport sink   (input valid, input data_byte, input packet_end, output ready);
endinterface

interface hhfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] value_byte;
    logic       end_marker;
    logic       found;
    logic       run_final;

    modport source (output valid, output value_byte, output end_marker, output found,
                    output run_final, input ready);
    modport sink   (input valid, input value_byte, input end_marker, input found,
                    input run_final, output ready);
endinterface

[src/http_header_field_extractor.sv]
// Top level of the HTTP header field extractor: configuration registers,
// window cell chain, field state machine and result queue.
// Depends on hhfe_pkg, hhfe_stream_if, hhfe_cell and hhfe_out_fifo.
//
//   Port      Direction  Handshake     Carries
//   in_ch     in         valid/ready   data_byte, packet_end
//   out_ch    out        valid/ready   value_byte, end_marker, found, run_final
//   cfg_*     in         write enable  cfg_index, cfg_wdata
//
// One input byte is taken per cycle while in_ch.ready is high; its results
// enter the queue at the same edge and leave one per cycle while out_ch.ready.
// The name compare is one parallel step across the cell chain, so the rate is
// set by the result queue: in_ch.ready is high while two queue entries are free.
// Reset clears all state but the queue entries at once; there is no clearing pass.
// A stalled out_ch only holds back in_ch once the queue is nearly full.
module http_header_field_extractor
    import hhfe_pkg::*;
#(
    parameter int NAME_MAX = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    hhfe_in_if.sink               in_ch,
    hhfe_out_if.source            out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int LEN_W = $clog2(NAME_MAX + 1);
    localparam int WIN   = NAME_MAX - 1;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_VALUE,
        PH_DONE
    } phase_t;

    logic [CFG_DATA_W-1:0]   name_low_reg;
    logic [CFG_DATA_W-1:0]   name_high_reg;
    logic [LEN_REG_W-1:0]    name_length_reg;
    logic [8*NAME_BYTES-1:0] name_all;
    logic [LEN_W-1:0]        eff_len;

    phase_t                  phase_reg;
    phase_t                  phase_next;
    logic                    held_cr_reg;
    logic                    held_cr_next;
    logic [LEN_W-1:0]        bytes_seen_reg;
    logic [LEN_W-1:0]        bytes_seen_next;
    logic [LEN_W-1:0]        seen_inc;

    logic                    in_acc;
    logic                    shift_en;
    logic                    win_clear;
    logic [7:0]              win_q     [WIN];
    logic [7:0]              win_cmp   [WIN];
    logic [WIN-1:0]          win_match;
    logic [WIN-1:0]          win_active;
    logic                    hit;

    result_t                 res_a;
    result_t                 res_b;
    logic [1:0]              push_n;
    result_t                 head;
    logic                    not_empty;
    logic                    room2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_low_reg    <= '0;
            name_high_reg   <= '0;
            name_length_reg <= LEN_REG_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NAME_LOW:  name_low_reg    <= cfg_wdata;
                CFG_NAME_HIGH: name_high_reg   <= cfg_wdata;
                CFG_NAME_LEN:  name_length_reg <= cfg_wdata[LEN_REG_W-1:0];
                default:       ;
            endcase
        end
    end

    assign name_all = {name_high_reg, name_low_reg};

    always_comb
    begin
        if (name_length_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (name_length_reg > LEN_REG_W'(NAME_MAX))
        begin
            eff_len = LEN_W'(NAME_MAX);
        end
        else
        begin
            eff_len = LEN_W'(name_length_reg);
        end
    end

    assign in_acc    = in_ch.valid && in_ch.ready;
    assign shift_en  = in_acc && (phase_reg == PH_SEARCH);
    assign win_clear = in_acc && in_ch.packet_end;

    for (genvar i = 0; i < WIN; i++)
    begin : g_cell
        assign win_active[i] = (LEN_W'(i + 1) < eff_len);
        assign win_cmp[i]    = name_byte(name_all,
                                   NIDX_W'(eff_len - LEN_W'(2) - LEN_W'(i)));

        hhfe_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift_en  (shift_en),
            .clear     (win_clear),
            .shift_in  ((i == 0) ? in_ch.data_byte : win_q[(i == 0) ? 0 : i - 1]),
            .cmp_byte  (win_cmp[i]),
            .shift_out (win_q[i]),
            .match     (win_match[i])
        );
    end

    assign seen_inc = (bytes_seen_reg == LEN_W'(NAME_MAX)) ? bytes_seen_reg
                                                           : bytes_seen_reg + LEN_W'(1);

    assign hit = (seen_inc >= eff_len)
              && (name_byte(name_all, NIDX_W'(eff_len - LEN_W'(1))) == in_ch.data_byte)
              && (&(win_match | ~win_active));

    always_comb
    begin
        phase_next      = phase_reg;
        held_cr_next    = held_cr_reg;
        bytes_seen_next = bytes_seen_reg;
        res_a           = '0;
        res_b           = '0;
        push_n          = 2'd0;
        if (in_acc)
        begin
            unique case (phase_reg)
                PH_SEARCH:
                begin
                    bytes_seen_next = seen_inc;
                    if (hit)
                    begin
                        phase_next = PH_VALUE;
                    end
                    if (in_ch.packet_end)
                    begin
                        res_a.end_marker = 1'b1;
                        push_n           = 2'd1;
                    end
                end
                PH_VALUE:
                begin
                    priority if (held_cr_reg && (in_ch.data_byte == CHAR_LF))
                    begin
                        held_cr_next     = 1'b0;
                        phase_next       = PH_DONE;
                        res_a.end_marker = 1'b1;
                        res_a.found      = 1'b1;
                        push_n           = 2'd1;
                    end
                    else if (in_ch.packet_end)
                    begin
                        res_a.end_marker = 1'b1;
                        push_n           = 2'd1;
                    end
                    else
                    begin
                        held_cr_next = (in_ch.data_byte == CHAR_CR);
                        if (held_cr_reg)
                        begin
                            res_a.value_byte = CHAR_CR;
                            push_n           = 2'd1;
                            if (in_ch.data_byte != CHAR_CR)
                            begin
                                res_b.value_byte = in_ch.data_byte;
                                push_n           = 2'd2;
                            end
                        end
                        else if (in_ch.data_byte != CHAR_CR)
                        begin
                            res_a.value_byte = in_ch.data_byte;
                            push_n           = 2'd1;
                        end
                    end
                end
                PH_DONE:
                begin
                end
                default:
                begin
                end
            endcase
            if (in_ch.packet_end)
            begin
                phase_next      = PH_SEARCH;
                held_cr_next    = 1'b0;
                bytes_seen_next = '0;
            end
        end
        res_a.run_final = (push_n == 2'd1);
        res_b.run_final = (push_n == 2'd2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SEARCH;
            held_cr_reg    <= 1'b0;
            bytes_seen_reg <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            held_cr_reg    <= held_cr_next;
            bytes_seen_reg <= bytes_seen_next;
        end
    end

    hhfe_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .push_a    (res_a),
        .push_b    (res_b),
        .pop       (out_ch.valid && out_ch.ready),
        .head      (head),
        .not_empty (not_empty),
        .room2     (room2)
    );

    assign in_ch.ready       = room2;
    assign out_ch.valid      = not_empty;
    assign out_ch.value_byte = head.value_byte;
    assign out_ch.end_marker = head.end_marker;
    assign out_ch.found      = head.found;
    assign out_ch.run_final  = head.run_final;

    a_cr_in_value: assert property (@(posedge clk) disable iff (!rst_n)
        held_cr_reg |-> (phase_reg == PH_VALUE))
        else $error("A CR is held outside the value phase.");

    a_packet_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && in_ch.packet_end) |=> ((phase_reg == PH_SEARCH)
                                          && (bytes_seen_reg == '0) && !held_cr_reg))
        else $error("State not cleared after the last byte of a packet.");

    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (phase_reg == PH_DONE)) |-> (push_n == 2'd0))
        else $error("Results produced after the field was complete.");

endmodule

[src/hhfe_cell.sv]
// One window cell: holds a recent byte, passes it on to the next cell and
// compares it with the name byte that lines up with it. No dependencies.
module hhfe_cell (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       shift_en,
    input  logic       clear,
    input  logic [7:0] shift_in,
    input  logic [7:0] cmp_byte,
    output logic [7:0] shift_out,
    output logic       match
);

    logic [7:0] byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else if (clear)
        begin
            byte_reg <= '0;
        end
        else if (shift_en)
        begin
            byte_reg <= shift_in;
        end
    end

    assign shift_out = byte_reg;
    assign match     = (byte_reg == cmp_byte);

endmodule

[src/hhfe_out_fifo.sv]
// Four-entry result queue that takes up to two results per cycle and
// delivers one. Depends on hhfe_pkg.
module hhfe_out_fifo
    import hhfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_n,
    input  result_t    push_a,
    input  result_t    push_b,
    input  logic       pop,
    output result_t    head,
    output logic       not_empty,
    output logic       room2
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(push_n) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push_a;
        end
        if (push_n == 2'd2)
        begin
            entry_reg[wr_ptr_reg + PTR_W'(1)] <= push_b;
        end
    end

    assign head      = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign room2     = (count_reg <= CNT_W'(DEPTH - 2));

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("Result queue holds more entries than its depth.");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n != 2'd0) |-> room2)
        else $error("Results pushed while the queue lacks room for two.");

    a_push_code: assert property (@(posedge clk) disable iff (!rst_n)
        push_n != 2'd3)
        else $error("More than two results pushed in one cycle.");

endmodule
